[hdl/tvig_pkg.sv]
`default_nettype none

package tvig_pkg;

	// Widths of the datapath and of the configuration fields.
	localparam int MAX_RANK  = 4;
	localparam int DATA_W    = 32;
	localparam int DIM_W     = 16;
	localparam int RANK_W    = 3;
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 2;
	localparam int DIM_IDX_W = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;

	// One restoring divider step per quotient bit.
	localparam int STEPS = DATA_W;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_BASE_OFFSET = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_VIEW_RANK   = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZES   = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_DIM_STRIDES = CFG_IDX_W'(3);

	// Reset values of the configuration registers.
	localparam logic [DATA_W-1:0] BASE_OFFSET_RST = '0;
	localparam logic [RANK_W-1:0] VIEW_RANK_RST   = RANK_W'(1);
	localparam logic [CFG_W-1:0]  DIM_SIZES_RST   = 64'h0001_0001_0001_0001;
	localparam logic [CFG_W-1:0]  DIM_STRIDES_RST = 64'h0000_0000_0000_0001;

	// A request as it moves from one dimension pass to the next.
	typedef struct packed {
		logic              valid;
		logic [DATA_W-1:0] num;
		logic [DATA_W-1:0] addr;
	} tvig_item_t;

	// A request inside the divider: partial remainder and dividend/quotient.
	typedef struct packed {
		logic              valid;
		logic [DIM_W-1:0]  rem;
		logic [DATA_W-1:0] num;
		logic [DATA_W-1:0] addr;
	} tvig_div_t;

	// Rank values above the maximum act as the maximum.
	function automatic logic [RANK_W-1:0] sat_rank(input logic [RANK_W-1:0] rank);
		return (rank > RANK_W'(MAX_RANK)) ? RANK_W'(MAX_RANK) : rank;
	endfunction

	// Dimension handled by pass p: the innermost active one comes first.
	function automatic logic [DIM_IDX_W-1:0] pass_dim(input logic [RANK_W-1:0] rank,
		input int p);
		logic [RANK_W-1:0] d;
		d = rank - RANK_W'(p) - RANK_W'(1);
		return d[DIM_IDX_W-1:0];
	endfunction

	// Divisor of pass p; an inactive pass or a zero size divides by one.
	function automatic logic [DIM_W-1:0] pass_size(input logic [CFG_W-1:0] sizes,
		input logic [RANK_W-1:0] rank, input int p);
		logic [DIM_W-1:0] s;
		s = sizes[pass_dim(rank, p)*DIM_W +: DIM_W];
		if (rank <= RANK_W'(p) || s == '0) begin
			return DIM_W'(1);
		end
		return s;
	endfunction

	// Stride of pass p; an inactive pass adds nothing.
	function automatic logic [DIM_W-1:0] pass_stride(input logic [CFG_W-1:0] strides,
		input logic [RANK_W-1:0] rank, input int p);
		if (rank <= RANK_W'(p)) begin
			return '0;
		end
		return strides[pass_dim(rank, p)*DIM_W +: DIM_W];
	endfunction

endpackage

`default_nettype wire

[hdl/tvig_div_stage.sv]
`default_nettype none

module tvig_div_stage (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       adv,
	input  wire logic [tvig_pkg::DIM_W-1:0] divisor,
	input  wire tvig_pkg::tvig_div_t        step_in,
	output tvig_pkg::tvig_div_t             step_out
);
	import tvig_pkg::*;

	logic [DIM_W:0]    trial;
	logic [DIM_W:0]    diff;
	logic              fits;
	logic              valid_s1;
	logic [DIM_W-1:0]  rem_s1;
	logic [DATA_W-1:0] num_s1;
	logic [DATA_W-1:0] addr_s1;

	// Bring down the next dividend bit and try to subtract the divisor.
	assign trial = {step_in.rem, step_in.num[DATA_W-1]};
	assign diff  = trial - {1'b0, divisor};
	assign fits  = (trial >= {1'b0, divisor});

	// Valid bit of this step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= step_in.valid;
		end
	end

	// The remainder stays below the divisor, so it fits in the field width.
	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s1  <= fits ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
			num_s1  <= {step_in.num[DATA_W-2:0], fits};
			addr_s1 <= step_in.addr;
		end
	end

	assign step_out = '{valid: valid_s1, rem: rem_s1, num: num_s1, addr: addr_s1};

endmodule

`default_nettype wire

[hdl/tvig_pass.sv]
`default_nettype none

module tvig_pass (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       adv,
	input  wire logic [tvig_pkg::DIM_W-1:0] divisor,
	input  wire logic [tvig_pkg::DIM_W-1:0] stride,
	input  wire tvig_pkg::tvig_item_t       item_in,
	output tvig_pkg::tvig_item_t            item_out
);
	import tvig_pkg::*;

	tvig_div_t                 chain [0:STEPS];
	logic signed [2*DIM_W:0]   prod_full;
	logic                      valid_s1;
	logic [DATA_W-1:0]         prod_s1;
	logic [DATA_W-1:0]         num_s1;
	logic [DATA_W-1:0]         addr_s1;
	logic                      valid_s2;
	logic [DATA_W-1:0]         num_s2;
	logic [DATA_W-1:0]         addr_s2;

	// The divider starts with a zero partial remainder.
	assign chain[0] = '{valid: item_in.valid, rem: '0, num: item_in.num,
		addr: item_in.addr};

	// One quotient bit per stage, most significant first.
	for (genvar i = 0; i < STEPS; i++) begin : g_step
		tvig_div_stage u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.divisor  (divisor),
			.step_in  (chain[i]),
			.step_out (chain[i+1])
		);
	end

	// Coordinate times signed stride; the low word is the product modulo 2^32.
	assign prod_full = $signed({1'b0, chain[STEPS].rem}) * $signed(stride);

	// Valid bits of the multiply and accumulate stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= chain[STEPS].valid;
			valid_s2 <= valid_s1;
		end
	end

	// Multiply, then add the product to the running address.
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= prod_full[DATA_W-1:0];
			num_s1  <= chain[STEPS].num;
			addr_s1 <= chain[STEPS].addr;
			num_s2  <= num_s1;
			addr_s2 <= addr_s1 + prod_s1;
		end
	end

	assign item_out = '{valid: valid_s2, num: num_s2, addr: addr_s2};

endmodule

`default_nettype wire

[hdl/tensor_view_index_generator.sv]
// Channel   Direction  Handshake               Payload
// cfg       in         cfg_we                  cfg_index, cfg_data
// in        in         in_valid / in_ready     flat_number
// out       out        out_valid / out_ready   memory_index
//
// One request enters per cycle while in_ready is high; its result is registered through
// four dimension passes of 34 register stages each (a 32-stage restoring divider, one
// multiply stage and one accumulate stage) before it shows on out_valid and memory_index.
// Reset clears the valid bits and loads the configuration reset values.
// A stall on the output freezes the whole pipeline; in_ready is low exactly then.
`default_nettype none

module tensor_view_index_generator (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [tvig_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [tvig_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [tvig_pkg::DATA_W-1:0]    flat_number,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [tvig_pkg::DATA_W-1:0]         memory_index
);
	import tvig_pkg::*;

	logic [DATA_W-1:0]   base_offset_q;
	logic [RANK_W-1:0]   view_rank_q;
	logic [CFG_W-1:0]    dim_sizes_q;
	logic [CFG_W-1:0]    dim_strides_q;
	logic [RANK_W-1:0]   rank_sat;
	logic                adv;
	tvig_item_t          items [0:MAX_RANK];
	logic [MAX_RANK-1:0] pass_valid;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_offset_q <= BASE_OFFSET_RST;
			view_rank_q   <= VIEW_RANK_RST;
			dim_sizes_q   <= DIM_SIZES_RST;
			dim_strides_q <= DIM_STRIDES_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BASE_OFFSET: base_offset_q <= cfg_data[DATA_W-1:0];
				REG_VIEW_RANK:   view_rank_q   <= cfg_data[RANK_W-1:0];
				REG_DIM_SIZES:   dim_sizes_q   <= cfg_data;
				REG_DIM_STRIDES: dim_strides_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign rank_sat = sat_rank(view_rank_q);

	// The pipeline moves whenever the output slot is empty or being taken.
	assign adv      = !items[MAX_RANK].valid || out_ready;
	assign in_ready = adv;

	assign items[0] = '{valid: in_valid, num: flat_number, addr: base_offset_q};

	// One pass per dimension, innermost active dimension first.
	for (genvar g = 0; g < MAX_RANK; g++) begin : g_pass
		tvig_pass u_pass (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.divisor  (pass_size(dim_sizes_q, rank_sat, g)),
			.stride   (pass_stride(dim_strides_q, rank_sat, g)),
			.item_in  (items[g]),
			.item_out (items[g+1])
		);
		assign pass_valid[g] = items[g+1].valid;
	end

	assign out_valid    = items[MAX_RANK].valid;
	assign memory_index = items[MAX_RANK].addr;

	// A stall holds every pass boundary in place.
	assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(pass_valid))
		else $error("pass valid bits changed during a stall");

	// With no active dimension the result is the base offset.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && view_rank_q == '0 |-> memory_index == base_offset_q)
		else $error("rank zero result differs from base offset");

	// With all strides zero every element maps to the base offset.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dim_strides_q == '0 |-> memory_index == base_offset_q)
		else $error("broadcast result differs from base offset");

endmodule

`default_nettype wire
